>>> rtl/smx_pkg.sv
// Shared types, opcodes, status codes and defaults for the stack machine executor.
// Used by smx_issue, smx_exec and stack_machine_executor; depends on nothing.
package smx_pkg;

   // Default sizes and the fixed word width
   localparam int STACK_DEPTH_DEF = 64;
   localparam int DATA_WORDS_DEF  = 64;
   localparam int WORD_BITS       = 32;
   localparam int ADDR_BITS       = 6;
   localparam int DEPTH_OUT_BITS  = 7;

   // Instruction opcodes
   localparam logic [2:0] OP_LOAD = 3'd0;
   localparam logic [2:0] OP_PUSH = 3'd1;
   localparam logic [2:0] OP_ADD  = 3'd2;
   localparam logic [2:0] OP_MULT = 3'd3;
   localparam logic [2:0] OP_POP  = 3'd4;
   localparam logic [2:0] OP_END  = 3'd5;

   // Result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_OVERFLOW  = 3'd1;
   localparam logic [2:0] ST_UNDERFLOW = 3'd2;
   localparam logic [2:0] ST_INVALID   = 3'd3;
   localparam logic [2:0] ST_HALTED    = 3'd4;

   // Datapath actions decided at issue
   localparam logic [2:0] ACT_NONE = 3'd0;
   localparam logic [2:0] ACT_LOAD = 3'd1;
   localparam logic [2:0] ACT_PUSH = 3'd2;
   localparam logic [2:0] ACT_ADD  = 3'd3;
   localparam logic [2:0] ACT_MUL  = 3'd4;
   localparam logic [2:0] ACT_POP  = 3'd5;

   typedef struct packed {
      logic [2:0]           req_type;
      logic [ADDR_BITS-1:0] word_addr;
      logic [WORD_BITS-1:0] write_value;
   } req_item_type;

   typedef struct packed {
      logic [2:0]                status;
      logic [WORD_BITS-1:0]      top_value;
      logic [DEPTH_OUT_BITS-1:0] stack_depth;
      logic                      halted_flag;
   } rsp_item_type;

   // Control handed from issue to the execute stage
   typedef struct packed {
      logic [2:0] act;
      logic [2:0] status;
      logic       stack_wen;
      logic       halted;
   } issue_ctl_type;

endpackage

>>> rtl/smx_issue.sv
// Issue stage: holds stack depth and halt state, checks each instruction and
// computes memory addresses. Depends on smx_pkg.
module smx_issue import smx_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int DATA_WORDS  = DATA_WORDS_DEF,
   localparam int CNT_W      = $clog2(STACK_DEPTH + 1),
   localparam int SAW        = $clog2(STACK_DEPTH),
   localparam int DAW        = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_fire,
   input  req_item_type  req_data,
   output issue_ctl_type ctl,
   output logic [CNT_W-1:0] count_ff,
   output logic [CNT_W-1:0] count_in,
   output logic          halted_ff,
   output logic [SAW-1:0] stack_raddr,
   output logic [SAW-1:0] stack_waddr,
   output logic [DAW-1:0] data_idx
);

   localparam int ADDR_SPAN = 2 ** ADDR_BITS;

   logic           halted_in;
   logic [DAW-1:0] wrap_tab [ADDR_SPAN];

   // Wrap data addresses modulo the memory size through a constant table
   for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_wrap
      assign wrap_tab[g] = DAW'(g % DATA_WORDS);
   end

   assign data_idx    = wrap_tab[req_data.word_addr];
   assign stack_raddr = SAW'(count_ff - CNT_W'(2));
   assign stack_waddr = SAW'(count_ff - CNT_W'(1));

   // Decide status, action and next depth for the offered item
   always_comb begin
      ctl.act       = ACT_NONE;
      ctl.status    = ST_OK;
      ctl.stack_wen = 1'b0;
      halted_in     = halted_ff;
      count_in      = count_ff;
      if (halted_ff) begin
         ctl.status = ST_HALTED;
      end else begin
         unique case (req_data.req_type)
            OP_LOAD: begin
               ctl.act = ACT_LOAD;
            end
            OP_PUSH: begin
               if (count_ff == CNT_W'(STACK_DEPTH)) begin
                  ctl.status = ST_OVERFLOW;
               end else begin
                  ctl.act       = ACT_PUSH;
                  ctl.stack_wen = (count_ff != '0);
                  count_in      = count_ff + CNT_W'(1);
               end
            end
            OP_ADD, OP_MULT: begin
               if (count_ff < CNT_W'(2)) begin
                  ctl.status = ST_UNDERFLOW;
               end else begin
                  ctl.act  = (req_data.req_type == OP_ADD) ? ACT_ADD : ACT_MUL;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  ctl.status = ST_UNDERFLOW;
               end else begin
                  ctl.act  = ACT_POP;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            OP_END: begin
               halted_in = 1'b1;
            end
            default: begin
               ctl.status = ST_INVALID;
            end
         endcase
         if (ctl.status != ST_OK) begin
            halted_in = 1'b1;
         end
      end
      ctl.halted = halted_in;
   end

   // Advance depth and halt state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         halted_ff <= 1'b0;
      end else if (req_fire) begin
         count_ff  <= count_in;
         halted_ff <= halted_in;
      end
   end

endmodule

>>> rtl/smx_exec.sv
// Execute stage: stack and data memories, read forwarding, adder and multiplier,
// and the top-of-stack register. Depends on smx_pkg.
module smx_exec import smx_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int DATA_WORDS  = DATA_WORDS_DEF,
   localparam int CNT_W      = $clog2(STACK_DEPTH + 1),
   localparam int SAW        = $clog2(STACK_DEPTH),
   localparam int DAW        = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  issue_ctl_type        ctl,
   input  logic [CNT_W-1:0]     count_in,
   input  logic [SAW-1:0]       stack_raddr,
   input  logic [SAW-1:0]       stack_waddr,
   input  logic [DAW-1:0]       data_idx,
   input  logic [WORD_BITS-1:0] write_value,
   input  logic                 s2_adv,
   output logic                 s1_valid_ff,
   output rsp_item_type         rsp_next
);

   logic [WORD_BITS-1:0] stack_mem [STACK_DEPTH];
   logic [WORD_BITS-1:0] word_mem  [DATA_WORDS];

   issue_ctl_type        s1_ctl_ff;
   logic [CNT_W-1:0]     s1_cnt_ff;
   logic [SAW-1:0]       s1_swaddr_ff;
   logic [DAW-1:0]       s1_didx_ff;
   logic [WORD_BITS-1:0] s1_wval_ff;

   logic [WORD_BITS-1:0] srd_ff, drd_ff;
   logic                 sfwd_ff, dfwd_ff;
   logic [WORD_BITS-1:0] sfwd_data_ff, dfwd_data_ff;
   logic [WORD_BITS-1:0] top_ff, top_in;

   logic                 st_wen, dm_wen;
   logic [WORD_BITS-1:0] dm_wdata;
   logic [WORD_BITS-1:0] a_op, d_op;

   // Write-back controls of the item in execute
   assign st_wen   = s2_adv && s1_ctl_ff.stack_wen;
   assign dm_wen   = s2_adv && ((s1_ctl_ff.act == ACT_LOAD) || (s1_ctl_ff.act == ACT_POP));
   assign dm_wdata = (s1_ctl_ff.act == ACT_LOAD) ? s1_wval_ff : top_ff;

   // Stack memory: spill old top on push, read entry below top at issue
   always_ff @(posedge clock) begin
      if (st_wen) begin
         stack_mem[s1_swaddr_ff] <= top_ff;
      end
      if (req_fire) begin
         srd_ff <= stack_mem[stack_raddr];
      end
   end

   // Data memory: write on load and pop, read at issue for push
   always_ff @(posedge clock) begin
      if (dm_wen) begin
         word_mem[s1_didx_ff] <= dm_wdata;
      end
      if (req_fire) begin
         drd_ff <= word_mem[data_idx];
      end
   end

   // Catch a write that lands on the entry being read in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         sfwd_ff <= 1'b0;
         dfwd_ff <= 1'b0;
      end else if (req_fire) begin
         sfwd_ff <= st_wen && (s1_swaddr_ff == stack_raddr);
         dfwd_ff <= dm_wen && (s1_didx_ff == data_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sfwd_data_ff <= top_ff;
         dfwd_data_ff <= dm_wdata;
         s1_ctl_ff    <= ctl;
         s1_cnt_ff    <= count_in;
         s1_swaddr_ff <= stack_waddr;
         s1_didx_ff   <= data_idx;
         s1_wval_ff   <= write_value;
      end
   end

   // Hold one item in execute until it moves to the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s2_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   assign a_op = sfwd_ff ? sfwd_data_ff : srd_ff;
   assign d_op = dfwd_ff ? dfwd_data_ff : drd_ff;

   // Compute the new top of stack
   always_comb begin
      unique case (s1_ctl_ff.act)
         ACT_PUSH: top_in = d_op;
         ACT_ADD:  top_in = a_op + top_ff;
         ACT_MUL:  top_in = a_op * top_ff;
         ACT_POP:  top_in = a_op;
         default:  top_in = top_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         top_ff <= top_in;
      end
   end

   // Form the result item
   always_comb begin
      rsp_next.status      = s1_ctl_ff.status;
      rsp_next.top_value   = (s1_cnt_ff == '0) ? '0 : top_in;
      rsp_next.stack_depth = DEPTH_OUT_BITS'(s1_cnt_ff);
      rsp_next.halted_flag = s1_ctl_ff.halted;
   end

endmodule

>>> rtl/stack_machine_executor.sv
// Top level of the stack machine executor: issue stage, execute stage and
// output register. Depends on smx_pkg, smx_issue and smx_exec.
//
// One instruction per item, one result item per instruction. The block takes
// one item per clock cycle when the result side keeps up. On acceptance the
// stack and data memories are read into the execute registers; when execute
// advances, it computes, writes back and loads the output register, where the
// result item stays until taken. While a result waits, one more item can sit
// in execute; after that the input stalls.
// The top of stack lives in a register, the entries below it in the stack
// memory, so each instruction needs at most one read of each memory. A write
// that hits the entry read by the next item is forwarded. The stack and data
// memories start undefined; no clearing pass is needed after reset.
module stack_machine_executor import smx_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int DATA_WORDS  = DATA_WORDS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int SAW   = $clog2(STACK_DEPTH);
   localparam int DAW   = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

   issue_ctl_type   ctl;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            halted_ff;
   logic [SAW-1:0]  stack_raddr, stack_waddr;
   logic [DAW-1:0]  data_idx;
   logic            s1_valid;
   logic            s2_adv;
   logic            req_fire;
   rsp_item_type    rsp_next;
   logic            rsp_valid_ff;
   rsp_item_type    rsp_data_ff;

   // Handshake: execute moves on when the output register is free or drains
   assign s2_adv    = s1_valid && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid || s2_adv;
   assign req_fire  = req_valid && req_ready;

   smx_issue #(
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WORDS  (DATA_WORDS)
   ) u_issue (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_data    (req_data),
      .ctl         (ctl),
      .count_ff    (count_ff),
      .count_in    (count_in),
      .halted_ff   (halted_ff),
      .stack_raddr (stack_raddr),
      .stack_waddr (stack_waddr),
      .data_idx    (data_idx)
   );

   smx_exec #(
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WORDS  (DATA_WORDS)
   ) u_exec (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .ctl         (ctl),
      .count_in    (count_in),
      .stack_raddr (stack_raddr),
      .stack_waddr (stack_waddr),
      .data_idx    (data_idx),
      .write_value (req_data.write_value),
      .s2_adv      (s2_adv),
      .s1_valid_ff (s1_valid),
      .rsp_next    (rsp_next)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Depth never passes the stack size
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack depth beyond stack size");

   // Halt holds until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt state cleared without reset");

   // Any error result reports the block halted
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_OK)) |-> rsp_data.halted_flag)
      else $error("error result without halt flag");

   // Input stalls only when execute and output register are both blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid && rsp_valid && !rsp_ready))
      else $error("input stalled without backpressure");

endmodule
